// ===== hdl/mbrp_pkg.sv =====
// Shared constants, job record type and helpers for the MBR/EBR partition table parser.
// No dependencies.
`default_nettype none

package mbrp_pkg;

  localparam int LBA_BITS = 48;

  localparam logic [8:0] TABLE_START  = 9'd446;
  localparam logic [8:0] SIG_LOW_POS  = 9'd510;
  localparam logic [8:0] SIG_HIGH_POS = 9'd511;

  localparam logic [7:0] SIG_LOW_BYTE  = 8'h55;
  localparam logic [7:0] SIG_HIGH_BYTE = 8'hAA;
  localparam logic [7:0] TYPE_GPT      = 8'hEE;
  localparam logic [7:0] TYPE_EXT_CHS  = 8'h05;
  localparam logic [7:0] TYPE_EXT_LBA  = 8'h0F;
  localparam logic [7:0] BOOT_FLAG     = 8'h80;

  localparam logic [1:0] KIND_PART   = 2'd0;
  localparam logic [1:0] KIND_FOLLOW = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SIG = 2'd1;
  localparam logic [1:0] ST_GPT     = 2'd2;

  localparam logic [2:0] DONE_SLOT = 3'd4;

  // One classified sector, handed from the byte front end to the emitter.
  typedef struct packed {
    logic                     sig_ok;
    logic                     is_ebr;
    logic                     gpt;
    logic [3:0]               used;
    logic [3:0]               ext;
    logic [3:0]               boot;
    logic [3:0][31:0]         start;
    logic [3:0][31:0]         sectors;
    logic [LBA_BITS-1:0]      sector_lba;
    logic [LBA_BITS-1:0]      ext_base;
  } job_t;

  function automatic logic is_ext(input logic [7:0] t);
    return (t == TYPE_EXT_CHS) || (t == TYPE_EXT_LBA);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mbrp_front.sv =====
// Byte front end: tracks sector position, captures the partition table and signature,
// and classifies the sector into a job record on its final byte. Uses mbrp_pkg.
`default_nettype none

module mbrp_front
  import mbrp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_is_ebr,
  input  wire logic [LBA_BITS-1:0] in_sector_lba,
  input  wire logic [LBA_BITS-1:0] in_ext_base,
  input  wire logic                q_full,
  output logic                     job_push,
  output job_t                     job
);

  logic [8:0]       pos_r;
  logic [8:0]       pos_nxt;
  logic [3:0][7:0]  type_r;
  logic [3:0]       boot_r;
  logic [3:0][31:0] start_r;
  logic [3:0][31:0] sec_r;
  logic [7:0]       sig_low_r;

  logic       acc;
  logic       in_table;
  logic [8:0] rel_full;
  logic [5:0] rel;
  logic [1:0] ent;
  logic [3:0] off;

  assign in_stall = (pos_r == SIG_HIGH_POS) && q_full;
  assign acc      = in_valid && !in_stall;
  assign in_table = (pos_r >= TABLE_START) && (pos_r < SIG_LOW_POS);
  assign rel_full = pos_r - TABLE_START;
  assign rel      = rel_full[5:0];
  assign ent      = rel[5:4];
  assign off      = rel[3:0];
  assign pos_nxt  = pos_r + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (acc) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_table) begin
      case (off) inside
        4'd0:           boot_r[ent] <= (in_data_byte == BOOT_FLAG);
        4'd4:           type_r[ent] <= in_data_byte;
        [4'd8:4'd11]:   start_r[ent][8*off[1:0] +: 8] <= in_data_byte;
        [4'd12:4'd15]:  sec_r[ent][8*off[1:0] +: 8] <= in_data_byte;
        default: ;
      endcase
    end
    if (acc && (pos_r == SIG_LOW_POS)) begin
      sig_low_r <= in_data_byte;
    end
  end

  always_comb begin
    job.sig_ok     = (sig_low_r == SIG_LOW_BYTE) && (in_data_byte == SIG_HIGH_BYTE);
    job.is_ebr     = in_is_ebr;
    job.gpt        = (type_r[0] == TYPE_GPT);
    job.boot       = boot_r;
    job.start      = start_r;
    job.sectors    = sec_r;
    job.sector_lba = in_sector_lba;
    job.ext_base   = in_ext_base;
    for (int i = 0; i < 4; i++) begin
      job.used[i] = (type_r[i] != 8'h00) && (sec_r[i] != 32'd0);
      job.ext[i]  = is_ext(type_r[i]);
    end
  end

  assign job_push = acc && (pos_r == SIG_HIGH_POS);

endmodule

`default_nettype wire

// ===== hdl/mbrp_jobq.sv =====
// Two-deep queue of classified sector jobs between front end and emitter.
// Uses mbrp_pkg for the job record.
`default_nettype none

module mbrp_jobq
  import mbrp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_data,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head
);

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("job queue underflow");

endmodule

`default_nettype wire

// ===== hdl/mbrp_back.sv =====
// Result emitter: walks the four entry slots and the done slot of the queued job,
// one slot a cycle unless stalled, into a registered output beat. Uses mbrp_pkg.
`default_nettype none

module mbrp_back
  import mbrp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                job_valid,
  input  job_t                     job,
  output logic                     job_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_kind,
  output logic [1:0]               out_entry_index,
  output logic [LBA_BITS-1:0]      out_start_lba,
  output logic [31:0]              out_length,
  output logic                     out_bootable,
  output logic [LBA_BITS-1:0]      out_chain_base,
  output logic [1:0]               out_status,
  output logic                     out_any_used,
  output logic                     out_last
);

  logic [2:0]          slot_r;
  logic [2:0]          slot_nxt;
  logic                out_valid_r;
  logic [1:0]          out_kind_r;
  logic [1:0]          out_idx_r;
  logic [LBA_BITS-1:0] out_start_r;
  logic [31:0]         out_len_r;
  logic                out_boot_r;
  logic [LBA_BITS-1:0] out_base_r;
  logic [1:0]          out_status_r;
  logic                out_found_r;
  logic                out_last_r;

  logic                adv;
  logic                is_done;
  logic [1:0]          s;
  logic [LBA_BITS-1:0] start_ext;
  logic [LBA_BITS-1:0] add_a;
  logic [LBA_BITS-1:0] sum;
  logic                emit;
  logic [1:0]          e_kind;
  logic [1:0]          e_idx;
  logic [LBA_BITS-1:0] e_start;
  logic [31:0]         e_len;
  logic                e_boot;
  logic [LBA_BITS-1:0] e_base;
  logic [1:0]          e_status;
  logic                e_found;

  assign adv       = job_valid && (!out_valid_r || !out_stall);
  assign is_done   = (slot_r == DONE_SLOT);
  assign s         = slot_r[1:0];
  assign start_ext = {{(LBA_BITS-32){1'b0}}, job.start[s]};
  assign add_a     = !job.is_ebr ? '0 : ((s == 2'd0) ? job.sector_lba : job.ext_base);
  assign sum       = add_a + start_ext;
  assign slot_nxt  = is_done ? 3'd0 : slot_r + 3'd1;
  assign job_pop   = adv && is_done;

  always_comb begin
    emit     = 1'b0;
    e_kind   = KIND_PART;
    e_idx    = 2'd0;
    e_start  = '0;
    e_len    = '0;
    e_boot   = 1'b0;
    e_base   = '0;
    e_status = ST_OK;
    e_found  = 1'b0;
    if (is_done) begin
      emit   = 1'b1;
      e_kind = KIND_DONE;
      if (!job.sig_ok) begin
        e_status = ST_BAD_SIG;
      end else if (!job.is_ebr && job.gpt) begin
        e_status = ST_GPT;
      end
      e_found = job.sig_ok && !job.is_ebr && !job.gpt && (|job.used);
    end else if (job.sig_ok) begin
      if (job.is_ebr) begin
        if ((s == 2'd0) && job.used[0]) begin
          emit    = 1'b1;
          e_start = sum;
          e_len   = job.sectors[0];
        end else if ((s == 2'd1) && job.ext[1]) begin
          emit    = 1'b1;
          e_kind  = KIND_FOLLOW;
          e_start = sum;
          e_len   = job.sectors[1];
          e_base  = job.ext_base;
        end
      end else if (!job.gpt && job.used[s]) begin
        emit    = 1'b1;
        e_idx   = s;
        e_start = sum;
        e_len   = job.sectors[s];
        if (job.ext[s]) begin
          e_kind = KIND_FOLLOW;
          e_base = start_ext;
        end else begin
          e_boot = job.boot[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        slot_r <= slot_nxt;
      end
      if (adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_kind_r   <= e_kind;
      out_idx_r    <= e_idx;
      out_start_r  <= e_start;
      out_len_r    <= e_len;
      out_boot_r   <= e_boot;
      out_base_r   <= e_base;
      out_status_r <= e_status;
      out_found_r  <= e_found;
      out_last_r   <= is_done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_entry_index = out_idx_r;
  assign out_start_lba   = out_start_r;
  assign out_length      = out_len_r;
  assign out_bootable    = out_boot_r;
  assign out_chain_base  = out_base_r;
  assign out_status      = out_status_r;
  assign out_any_used    = out_found_r;
  assign out_last        = out_last_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= DONE_SLOT)
    else $error("slot counter out of range");

  a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_kind_r == KIND_DONE)))
    else $error("last flag does not match done record");

  a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r != KIND_DONE)) |-> (out_status_r == ST_OK && !out_found_r))
    else $error("status or found flag on a non-done record");

  a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (slot_r == 3'd0))
    else $error("slot walk did not restart after done");

endmodule

`default_nettype wire

// ===== hdl/mbr_partition_table_parser.sv =====
// Top level of the MBR/EBR partition table parser: front end, job queue and emitter.
// Depends on mbrp_pkg, mbrp_front, mbrp_jobq and mbrp_back.
//
// Usage: stream a sector as 512 beats on the in_ channel, bytes 0..511 in order.
// in_is_ebr, in_sector_lba and in_ext_base are sampled with byte 511 only.
// Each sector yields one to five beats on the out_ channel in entry order:
// partitions, follow requests for extended entries, then a done beat with
// out_last set.
// Throughput: one byte per cycle while in_stall is low. The sector is classified
// as byte 511 is taken and queued; the emitter walks four entry slots and the
// done slot, one slot a cycle while out_stall does not hold an output beat. The
// first result of a sector passes through the queue register and then the output
// register. The two-deep queue holds finished sectors while the receiver stalls;
// in_stall rises only on byte 511 when both queue slots are taken. A stalled
// out_ beat holds. Reset clears the byte position, the queue and the output
// valid; the next byte taken is byte 0 of a sector.
`default_nettype none

module mbr_partition_table_parser
  import mbrp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_is_ebr,
  input  wire logic [LBA_BITS-1:0] in_sector_lba,
  input  wire logic [LBA_BITS-1:0] in_ext_base,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_kind,
  output logic [1:0]               out_entry_index,
  output logic [LBA_BITS-1:0]      out_start_lba,
  output logic [31:0]              out_length,
  output logic                     out_bootable,
  output logic [LBA_BITS-1:0]      out_chain_base,
  output logic [1:0]               out_status,
  output logic                     out_any_used,
  output logic                     out_last
);

  logic job_push;
  job_t job_in;
  logic q_full;
  logic job_pop;
  logic head_valid;
  job_t head;

  mbrp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_is_ebr     (in_is_ebr),
    .in_sector_lba (in_sector_lba),
    .in_ext_base   (in_ext_base),
    .q_full        (q_full),
    .job_push      (job_push),
    .job           (job_in)
  );

  mbrp_jobq u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  (job_in),
    .full       (q_full),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mbrp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (head_valid),
    .job             (head),
    .job_pop         (job_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_entry_index (out_entry_index),
    .out_start_lba   (out_start_lba),
    .out_length      (out_length),
    .out_bootable    (out_bootable),
    .out_chain_base  (out_chain_base),
    .out_status      (out_status),
    .out_any_used    (out_any_used),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ===== dv/mbr_record_checker.sv =====
// Checker for mbr_partition_table_parser: follows the byte beats of each 512-byte sector,
// predicts the records of the sector and compares each out_ beat with them field by field.
// Depends on mbrp_pkg.
module mbr_record_checker
  import mbrp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_is_ebr,
  input  logic [LBA_BITS-1:0] in_sector_lba,
  input  logic [LBA_BITS-1:0] in_ext_base,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [1:0]          out_kind,
  input  logic [1:0]          out_entry_index,
  input  logic [LBA_BITS-1:0] out_start_lba,
  input  logic [31:0]         out_length,
  input  logic                out_bootable,
  input  logic [LBA_BITS-1:0] out_chain_base,
  input  logic [1:0]          out_status,
  input  logic                out_any_used,
  input  logic                out_last,
  output int                  errors,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]          kind;
    logic [1:0]          idx;
    logic [LBA_BITS-1:0] start;
    logic [31:0]         len;
    logic                boot;
    logic [LBA_BITS-1:0] base;
    logic [1:0]          status;
    logic                found;
    logic                last;
  } table_rec_t;

  table_rec_t  sector_recs_q[$];
  logic [8:0]  byte_pos;
  logic [7:0]  ent_type [4];
  logic        ent_boot [4];
  logic [31:0] ent_start [4];
  logic [31:0] ent_len [4];
  logic [7:0]  sig_low;
  int          rec_seq;

  function automatic logic chain_type(input logic [7:0] t);
    return (t == TYPE_EXT_CHS) || (t == TYPE_EXT_LBA);
  endfunction

  task automatic flag(input string msg);
    errors++;
    $display("mbr_record_checker: %s", msg);
  endtask

  task automatic cmp_field(input string name, input logic [63:0] g, input logic [63:0] w);
    if (g !== w) begin
      flag($sformatf("record %0d: %s is 0x%0h, predicted 0x%0h", rec_seq, name, g, w));
    end
  endtask

  task automatic queue_rec(input logic [1:0] kind, input logic [1:0] idx,
                           input logic [LBA_BITS-1:0] start, input logic [31:0] len,
                           input logic boot, input logic [LBA_BITS-1:0] base,
                           input logic [1:0] status, input logic found, input logic last);
    table_rec_t r;
    r = '{kind, idx, start, len, boot, base, status, found, last};
    sector_recs_q.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    logic [5:0] rel;
    logic       found;
    table_rec_t got;
    table_rec_t want;
    if (!rst_n) begin
      byte_pos = '0;
      errors = 0;
      rec_seq = 0;
      sector_recs_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_kind, out_entry_index, out_start_lba, out_length, out_bootable,
                out_chain_base, out_status, out_any_used, out_last};
        rec_seq++;
        if (sector_recs_q.size() == 0) begin
          flag($sformatf("record %0d: beat with nothing pending, kind %0d", rec_seq, out_kind));
        end else begin
          want = sector_recs_q.pop_front();
          cmp_field("kind", got.kind, want.kind);
          cmp_field("entry_index", got.idx, want.idx);
          cmp_field("start_lba", got.start, want.start);
          cmp_field("length", got.len, want.len);
          cmp_field("bootable", got.boot, want.boot);
          cmp_field("chain_base", got.base, want.base);
          cmp_field("status", got.status, want.status);
          cmp_field("any_used", got.found, want.found);
          cmp_field("last", got.last, want.last);
        end
      end

      if (in_valid && !in_stall) begin
        if (byte_pos >= TABLE_START && byte_pos < SIG_LOW_POS) begin
          rel = 6'(byte_pos - TABLE_START);
          case (rel[3:0])
            4'd0: ent_boot[rel[5:4]] = (in_data_byte == BOOT_FLAG);
            4'd4: ent_type[rel[5:4]] = in_data_byte;
            4'd8, 4'd9, 4'd10, 4'd11:
              ent_start[rel[5:4]][8 * (rel[3:0] - 8) +: 8] = in_data_byte;
            4'd12, 4'd13, 4'd14, 4'd15:
              ent_len[rel[5:4]][8 * (rel[3:0] - 12) +: 8] = in_data_byte;
            default: ;
          endcase
        end else if (byte_pos == SIG_LOW_POS) begin
          sig_low = in_data_byte;
        end else if (byte_pos == SIG_HIGH_POS) begin
          found = 1'b0;
          if (sig_low != SIG_LOW_BYTE || in_data_byte != SIG_HIGH_BYTE) begin
            queue_rec(KIND_DONE, '0, '0, '0, 1'b0, '0, ST_BAD_SIG, 1'b0, 1'b1);
          end else if (in_is_ebr) begin
            // only slot 0 (logical) and slot 1 (next link) count in an EBR
            if (ent_type[0] != 8'h00 && ent_len[0] != 32'h0) begin
              queue_rec(KIND_PART, '0, in_sector_lba + ent_start[0], ent_len[0], 1'b0, '0,
                        ST_OK, 1'b0, 1'b0);
            end
            if (chain_type(ent_type[1])) begin
              queue_rec(KIND_FOLLOW, '0, in_ext_base + ent_start[1], ent_len[1], 1'b0,
                        in_ext_base, ST_OK, 1'b0, 1'b0);
            end
            queue_rec(KIND_DONE, '0, '0, '0, 1'b0, '0, ST_OK, 1'b0, 1'b1);
          end else if (ent_type[0] == TYPE_GPT) begin
            queue_rec(KIND_DONE, '0, '0, '0, 1'b0, '0, ST_GPT, 1'b0, 1'b1);
          end else begin
            for (int e = 0; e < 4; e++) begin
              if (ent_type[e] != 8'h00 && ent_len[e] != 32'h0) begin
                found = 1'b1;
                if (chain_type(ent_type[e])) begin
                  queue_rec(KIND_FOLLOW, 2'(e), ent_start[e], ent_len[e], 1'b0, ent_start[e],
                            ST_OK, 1'b0, 1'b0);
                end else begin
                  queue_rec(KIND_PART, 2'(e), ent_start[e], ent_len[e], ent_boot[e], '0,
                            ST_OK, 1'b0, 1'b0);
                end
              end
            end
            queue_rec(KIND_DONE, '0, '0, '0, 1'b0, '0, ST_OK, found, 1'b1);
          end
        end
        byte_pos = byte_pos + 9'd1;
      end
    end
    outstanding <= sector_recs_q.size();
  end

endmodule

// ===== dv/tb_mbr_partition_table_parser.sv =====
// Top of the mbr_partition_table_parser testbench: clock, reset, sector stimulus and
// receiver stalls; checking is done by mbr_record_checker. Depends on mbrp_pkg.
module tb_mbr_partition_table_parser
  import mbrp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 2500;
  localparam int QUIET_LIMIT = 10000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          in_data_byte;
  logic                in_is_ebr;
  logic [LBA_BITS-1:0] in_sector_lba;
  logic [LBA_BITS-1:0] in_ext_base;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          out_kind;
  logic [1:0]          out_entry_index;
  logic [LBA_BITS-1:0] out_start_lba;
  logic [31:0]         out_length;
  logic                out_bootable;
  logic [LBA_BITS-1:0] out_chain_base;
  logic [1:0]          out_status;
  logic                out_any_used;
  logic                out_last;
  int                  errors;
  int                  outstanding;
  int                  hold_reqs = 0;

  logic [7:0] sector_img [512];

  mbr_partition_table_parser dut (.*);
  mbr_record_checker chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [LBA_BITS-1:0] random_lba();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return LBA_BITS'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [31:0] random_u32();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(1, 4096));
      default: return 32'($urandom);
    endcase
  endfunction

  // random filler, all four slots empty, good signature
  task automatic fresh_sector();
    for (int i = 0; i < 512; i++) sector_img[i] = 8'($urandom);
    for (int e = 0; e < 4; e++) sector_img[TABLE_START + 16 * e + 4] = 8'h00;
    sector_img[SIG_LOW_POS]  = SIG_LOW_BYTE;
    sector_img[SIG_HIGH_POS] = SIG_HIGH_BYTE;
  endtask

  task automatic set_entry(input int e, input logic [7:0] boot, input logic [7:0] ptype,
                           input logic [31:0] start, input logic [31:0] len);
    int at;
    at = TABLE_START + 16 * e;
    sector_img[at]     = boot;
    sector_img[at + 4] = ptype;
    for (int k = 0; k < 4; k++) begin
      sector_img[at + 8 + k]  = start[8 * k +: 8];
      sector_img[at + 12 + k] = len[8 * k +: 8];
    end
  endtask

  // one beat per byte; sector fields are only meaningful on byte 511
  task automatic send_sector(input logic ebr, input logic [LBA_BITS-1:0] slba,
                             input logic [LBA_BITS-1:0] base, input bit idle);
    int gap;
    for (int i = 0; i < 512; i++) begin
      gap = idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid      <= 1'b1;
      in_data_byte  <= sector_img[i];
      in_is_ebr     <= (i == 511) ? ebr : 1'($urandom);
      in_sector_lba <= (i == 511) ? slba : random_lba();
      in_ext_base   <= (i == 511) ? base : random_lba();
      do @(posedge clk); while (in_stall);
    end
  endtask

  task automatic random_sector(input bit idle);
    int         shape;
    logic [7:0] ptype;
    logic [7:0] boot;
    shape = $urandom_range(0, 9);
    fresh_sector();
    if (shape == 0) begin
      for (int e = 0; e < 4; e++) sector_img[TABLE_START + 16 * e + 4] = 8'($urandom);
      sector_img[SIG_LOW_POS]  = 8'($urandom);
      sector_img[SIG_HIGH_POS] = 8'($urandom);
    end else begin
      for (int e = 0; e < 4; e++) begin
        case ($urandom_range(0, 7))
          0: ptype = 8'h00;
          1: ptype = TYPE_EXT_CHS;
          2: ptype = TYPE_EXT_LBA;
          3: ptype = TYPE_GPT;
          default: ptype = 8'($urandom);
        endcase
        boot = ($urandom_range(0, 2) == 0) ? BOOT_FLAG : 8'($urandom);
        set_entry(e, boot, ptype, random_u32(), random_u32());
      end
      if (shape == 1) begin
        sector_img[SIG_LOW_POS + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
      end
    end
    send_sector(1'($urandom), random_lba(), random_lba(), idle);
  endtask

  initial begin : receiver
    int   gap;
    bit   idle;
    int   hold_taken;
    out_stall = 1'b0;
    idle = 1'b1;
    hold_taken = 0;
    @(posedge clk);
    forever begin
      if (hold_taken != hold_reqs) begin
        hold_taken = hold_reqs;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 23) == 0) idle = !idle;
      gap = idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && hold_taken == hold_reqs);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb_mbr_partition_table_parser: done, errors");
    $finish;
  end

  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = 8'h00;
    in_is_ebr     = 1'b0;
    in_sector_lba = '0;
    in_ext_base   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // MBR with all four slots used: partitions, both extended types, start/length extremes
    fresh_sector();
    set_entry(0, BOOT_FLAG, 8'h83, 32'h0, 32'hFFFF_FFFF);
    set_entry(1, 8'h00, TYPE_EXT_CHS, 32'hFFFF_FFFF, 32'h1);
    set_entry(2, 8'h7F, TYPE_EXT_LBA, 32'h1234_5678, 32'h800);
    set_entry(3, 8'h81, 8'hFF, 32'h1, 32'h7);
    send_sector(1'b0, random_lba(), random_lba(), $urandom_range(0, 2) == 0);

    // empty slots: zero type with a length, typed with zero length
    fresh_sector();
    set_entry(1, BOOT_FLAG, 8'h07, 32'h800, 32'h0);
    set_entry(3, 8'h00, TYPE_EXT_CHS, 32'h100, 32'h0);
    send_sector(1'b0, random_lba(), random_lba(), 1'b0);

    // GPT protective in slot 0
    fresh_sector();
    set_entry(0, 8'h00, TYPE_GPT, 32'h1, 32'hFFFF_FFFF);
    set_entry(1, BOOT_FLAG, 8'h83, 32'h800, 32'h64);
    send_sector(1'b0, random_lba(), random_lba(), 1'b0);

    // GPT type outside slot 0 is a plain partition
    fresh_sector();
    set_entry(2, BOOT_FLAG, TYPE_GPT, 32'h1, 32'h5);
    send_sector(1'b0, random_lba(), random_lba(), 1'b1);

    // GPT type in an EBR is a plain logical partition
    fresh_sector();
    set_entry(0, BOOT_FLAG, TYPE_GPT, 32'h3F, 32'h9);
    send_sector(1'b1, '0, '0, 1'b0);

    // bad low signature byte
    fresh_sector();
    set_entry(0, BOOT_FLAG, 8'h83, 32'h800, 32'h100);
    sector_img[SIG_LOW_POS] = 8'h54;
    send_sector(1'b0, random_lba(), random_lba(), 1'b0);

    // bad high signature byte wins over GPT
    fresh_sector();
    set_entry(0, 8'h00, TYPE_GPT, 32'h1, 32'h10);
    sector_img[SIG_HIGH_POS] = 8'h55;
    send_sector(1'b0, random_lba(), random_lba(), 1'b0);

    // swapped signature on an EBR
    fresh_sector();
    set_entry(0, 8'h00, 8'h83, 32'h3F, 32'h10);
    set_entry(1, 8'h00, TYPE_EXT_CHS, 32'h40, 32'h10);
    sector_img[SIG_LOW_POS]  = SIG_HIGH_BYTE;
    sector_img[SIG_HIGH_POS] = SIG_LOW_BYTE;
    send_sector(1'b1, random_lba(), random_lba(), 1'b0);

    // EBR logical and link, both sums wrap; slots 2 and 3 ignored
    fresh_sector();
    set_entry(0, BOOT_FLAG, 8'h83, 32'hFFFF_FFFF, 32'h64);
    set_entry(1, 8'h00, TYPE_EXT_LBA, 32'h10, 32'h20);
    set_entry(2, BOOT_FLAG, 8'h83, 32'h5, 32'h5);
    set_entry(3, 8'h00, TYPE_EXT_CHS, 32'h6, 32'h6);
    send_sector(1'b1, '1, '1, 1'b0);

    // EBR: zero-length logical skipped, zero-length link still followed
    fresh_sector();
    set_entry(0, 8'h00, 8'h83, 32'h5, 32'h0);
    set_entry(1, 8'h00, TYPE_EXT_CHS, 32'h0, 32'h0);
    send_sector(1'b1, random_lba(), random_lba(), 1'b1);

    // EBR: empty logical, non-extended slot 1
    fresh_sector();
    set_entry(0, 8'h00, 8'h00, 32'h5, 32'h9);
    set_entry(1, 8'h00, 8'h83, 32'h7, 32'h7);
    send_sector(1'b1, random_lba(), random_lba(), 1'b0);

    for (int n = 0; n < 32; n++) random_sector($urandom_range(0, 2) == 0);

    // receiver holds off while sectors keep coming, so the queue fills
    hold_reqs++;
    for (int n = 0; n < 5; n++) random_sector(1'b0);

    for (int n = 0; n < 4; n++) random_sector($urandom_range(0, 2) == 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_mbr_partition_table_parser: done, clean");
    end else begin
      $display("tb_mbr_partition_table_parser: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mbrp_pkg.sv
hdl/mbrp_front.sv
hdl/mbrp_jobq.sv
hdl/mbrp_back.sv
hdl/mbr_partition_table_parser.sv
dv/mbr_record_checker.sv
dv/tb_mbr_partition_table_parser.sv
